// ===== sv/svcd_pkg.sv =====
// Shared types and constants for the sparse voxel chunk decoder.
// No dependencies; the parser, the top level and the bench refer to it by scoped name.
package svcd_pkg;

  // Default number of blocks in a chunk store; indexes at or above it are rejected.
  localparam int unsigned BLOCK_COUNT_DEF = 4096;

  // The only chunk format version the parser accepts.
  localparam logic [7:0] FORMAT_VERSION = 8'd1;

  // Frame outcome reported with frame_done.
  typedef enum logic [1:0] {
    STATUS_OK          = 2'd0,
    STATUS_TOO_SHORT   = 2'd1,
    STATUS_BAD_VERSION = 2'd2,
    STATUS_RANGE       = 2'd3
  } status_t;

  // Per-byte result, minus the chunk position that is held in the parser.
  typedef struct packed {
    logic        store_write;
    logic [11:0] store_index;
    logic [7:0]  store_value;
    logic        clear_store;
    logic        frame_done;
    status_t     status;
  } result_t;

endpackage

// ===== sv/svcd_if.sv =====
// Valid/ready channel interfaces for the sparse voxel chunk decoder.
// No dependencies: byte words in, one result word out per byte.
interface svcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface svcd_out_if;
  logic               valid;
  logic               ready;
  logic               store_write;
  logic        [11:0] store_index;
  logic        [7:0]  store_value;
  logic               clear_store;
  logic               frame_done;
  logic        [1:0]  status;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (
    output valid, output store_write, output store_index, output store_value,
    output clear_store, output frame_done, output status,
    output pos_x, output pos_y, output pos_z,
    input ready
  );
  modport sink (
    input valid, input store_write, input store_index, input store_value,
    input clear_store, input frame_done, input status,
    input pos_x, input pos_y, input pos_z,
    output ready
  );
endinterface

// ===== sv/svcd_parse.sv =====
// Field state machine of the chunk decoder: holds the parse state and position words.
// Depends on svcd_pkg for the result struct, status codes and format version.
module svcd_parse #(
  parameter int unsigned BLOCK_COUNT = svcd_pkg::BLOCK_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        data_byte,
  input  logic              last_byte,
  output svcd_pkg::result_t res,
  output logic [31:0]       pos [3]
);

  typedef enum logic [2:0] {
    PH_VERSION,
    PH_POSITION,
    PH_COUNT,
    PH_INDEX,
    PH_VALUE,
    PH_DRAIN
  } phase_t;

  localparam logic [32:0] BlockLimit = 33'(BLOCK_COUNT);

  phase_t            phase, phase_next;
  logic [3:0]        byte_in_field, byte_in_field_next;
  logic [31:0]       field_word, field_word_next;
  logic [31:0]       entries_left, entries_left_next;
  logic [31:0]       pos_next [3];
  svcd_pkg::status_t error_code, error_code_next;

  logic [31:0]       field_acc;
  logic [3:0]        byte_inc;
  logic [1:0]        word_sel;
  logic [31:0]       left_dec;
  logic              ended;
  logic              was_drain;
  svcd_pkg::status_t err;

  always_comb begin
    field_acc = field_word;
    field_acc[{byte_in_field[1:0], 3'b000} +: 8] =
      field_word[{byte_in_field[1:0], 3'b000} +: 8] | data_byte;
    byte_inc  = byte_in_field + 4'd1;
    word_sel  = byte_inc[3:2] - 2'd1;
    left_dec  = entries_left - 32'd1;
    was_drain = (phase == PH_DRAIN);

    phase_next         = phase;
    byte_in_field_next = byte_in_field;
    field_word_next    = field_word;
    entries_left_next  = entries_left;
    pos_next           = pos;
    error_code_next    = error_code;
    res                = '0;
    ended              = 1'b0;
    err                = svcd_pkg::STATUS_OK;

    unique case (phase)
      PH_VERSION: begin
        if (data_byte != svcd_pkg::FORMAT_VERSION) begin
          err   = svcd_pkg::STATUS_BAD_VERSION;
          ended = 1'b1;
        end else begin
          phase_next         = PH_POSITION;
          byte_in_field_next = '0;
          field_word_next    = '0;
        end
      end
      PH_POSITION: begin
        field_word_next    = field_acc;
        byte_in_field_next = byte_inc;
        if (byte_inc[1:0] == 2'd0) begin
          if (word_sel != 2'd3) pos_next[word_sel] = field_acc;
          field_word_next = '0;
        end
        if (byte_inc >= 4'd12) begin
          phase_next         = PH_COUNT;
          byte_in_field_next = '0;
        end
      end
      PH_COUNT: begin
        field_word_next    = field_acc;
        byte_in_field_next = byte_inc;
        if (byte_inc >= 4'd4) begin
          entries_left_next  = field_acc;
          field_word_next    = '0;
          byte_in_field_next = '0;
          res.clear_store    = 1'b1;
          if (field_acc == '0) ended = 1'b1;
          else phase_next = PH_INDEX;
        end
      end
      PH_INDEX: begin
        field_word_next    = field_acc;
        byte_in_field_next = byte_inc;
        if (byte_inc >= 4'd4) begin
          byte_in_field_next = '0;
          phase_next         = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if ({1'b0, field_word} >= BlockLimit) begin
          err   = svcd_pkg::STATUS_RANGE;
          ended = 1'b1;
        end else begin
          res.store_write   = 1'b1;
          res.store_index   = field_word[11:0];
          res.store_value   = data_byte;
          entries_left_next = left_dec;
          field_word_next   = '0;
          if (left_dec == '0) ended = 1'b1;
          else phase_next = PH_INDEX;
        end
      end
      PH_DRAIN: begin
      end
      default: phase_next = PH_DRAIN;
    endcase

    // A marked last byte that leaves the frame unfinished means the buffer was cut short.
    if (!was_drain && !ended && last_byte) begin
      err   = svcd_pkg::STATUS_TOO_SHORT;
      ended = 1'b1;
    end

    if (ended) begin
      res.frame_done  = 1'b1;
      res.status      = err;
      error_code_next = err;
      phase_next      = PH_DRAIN;
    end else if (was_drain) begin
      res.frame_done = last_byte;
      res.status     = last_byte ? error_code : svcd_pkg::STATUS_OK;
    end

    // Restart at the version byte on every marked last byte; position words survive.
    if (last_byte) begin
      phase_next         = PH_VERSION;
      byte_in_field_next = '0;
      field_word_next    = '0;
      entries_left_next  = '0;
      error_code_next    = svcd_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_VERSION;
      byte_in_field <= '0;
      field_word    <= '0;
      entries_left  <= '0;
      pos[0]        <= '0;
      pos[1]        <= '0;
      pos[2]        <= '0;
      error_code    <= svcd_pkg::STATUS_OK;
    end else if (advance) begin
      phase         <= phase_next;
      byte_in_field <= byte_in_field_next;
      field_word    <= field_word_next;
      entries_left  <= entries_left_next;
      pos           <= pos_next;
      error_code    <= error_code_next;
    end
  end

endmodule

// ===== sv/sparse_voxel_chunk_decoder.sv =====
// Top level of the sparse voxel chunk decoder: handshake, result register, checks.
// Depends on svcd_pkg, the channel interfaces in svcd_if.sv and svcd_parse.
//
// Takes a serialized sparse chunk one byte word per cycle and gives exactly one
// result word per byte: a version byte (must be 1), three little-endian signed
// 32-bit position words, a 32-bit entry count, then entries of a 32-bit block
// index and a value byte. The count field raises clear_store; each good entry
// raises store_write with its index and value. frame_done marks the byte that
// ends parsing (completion or error) and a last byte seen while draining; status
// then carries the outcome (ok, too short, bad version, index out of range).
// Throughput is one byte per clock unless the receiver holds the result register:
// the whole field state machine is combinational, and its result lands in one
// output register, so the result for a byte appears in the cycle after the byte
// is taken. The input side stays ready whenever that register is empty or being
// read in the same cycle. pos_x/y/z show the position words as of the byte that
// made the current result; they are kept across frames.
module sparse_voxel_chunk_decoder #(
  parameter int unsigned BLOCK_COUNT = svcd_pkg::BLOCK_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  svcd_in_if.sink   chunk,
  svcd_out_if.source result
);

  logic              accept;
  logic              out_valid;
  svcd_pkg::result_t res_comb;
  svcd_pkg::result_t res_q;
  logic [31:0]       pos [3];

  // Take a new byte whenever the result register is empty or drains this cycle.
  assign chunk.ready = !out_valid || result.ready;
  assign accept      = chunk.valid && chunk.ready;

  svcd_parse #(
    .BLOCK_COUNT(BLOCK_COUNT)
  ) u_parse (
    .clk       (clk),
    .rst       (rst),
    .advance   (accept),
    .data_byte (chunk.data_byte),
    .last_byte (chunk.last_byte),
    .res       (res_comb),
    .pos       (pos)
  );

  // Hold the result word until it is taken; load a new one on every accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_q <= res_comb;
    end
  end

  // The position registers advance together with the result register, so they
  // already match the word on display.
  assign result.valid       = out_valid;
  assign result.store_write = res_q.store_write;
  assign result.store_index = res_q.store_index;
  assign result.store_value = res_q.store_value;
  assign result.clear_store = res_q.clear_store;
  assign result.frame_done  = res_q.frame_done;
  assign result.status      = res_q.status;
  assign result.pos_x       = pos[0];
  assign result.pos_y       = pos[1];
  assign result.pos_z       = pos[2];

`ifndef SYNTHESIS
  // The count field and an entry never finish on the same byte.
  a_clear_not_write: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(res_q.clear_store && res_q.store_write))
    else $error("clear_store and store_write raised together");

  // A nonzero status is only reported on the byte that ends the frame.
  a_status_with_done: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res_q.status != svcd_pkg::STATUS_OK) |-> res_q.frame_done)
    else $error("nonzero status without frame_done");

  // An empty result register never stalls the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> chunk.ready)
    else $error("input stalled with empty result register");

  // Every accepted byte leaves a result word on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted byte produced no result word");
`endif

endmodule

// ===== tb/sparse_voxel_chunk_decoder_tb.sv =====
// Self-checking bench for sparse_voxel_chunk_decoder: byte words in, one result word out.
// Depends on svcd_pkg and the channel interfaces in svcd_if.sv; predicts every result
// with its own copy of the chunk parser and compares field by field.
module sparse_voxel_chunk_decoder_tb;

  localparam int unsigned BLOCKS = svcd_pkg::BLOCK_COUNT_DEF;
  localparam int RANDOM_BYTES = 720;
  // Allow far more than the longest sender gap plus the longest receiver stall.
  localparam int WATCHDOG_CYCLES = 600;
  // Settling time after the drain, covering the result register, before the verdict.
  localparam int TAIL_CYCLES = 8;

  // Field state machine of the parser, tracked by the predictor.
  typedef enum logic [2:0] {
    PH_VERSION, PH_POSITION, PH_COUNT, PH_INDEX, PH_VALUE, PH_DRAIN
  } parse_phase_t;

  // One predicted result word: the packed result plus the position words.
  typedef struct {
    svcd_pkg::result_t res;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [31:0]       pz;
  } decoded_word_t;

  logic clk;
  logic rst;

  svcd_in_if  chunk_if ();
  svcd_out_if result_if ();

  sparse_voxel_chunk_decoder #(.BLOCK_COUNT(BLOCKS)) DUT (
    .clk    (clk),
    .rst    (rst),
    .chunk  (chunk_if),
    .result (result_if)
  );

  // Predictor state: a private copy of the parser.
  parse_phase_t      cur_phase;
  logic [3:0]        field_cnt;
  logic [31:0]       field_acc;
  logic [31:0]       entries_rem;
  logic [31:0]       pos_words [3];
  svcd_pkg::status_t frame_err;

  decoded_word_t pending_results[$];
  logic [7:0]    frame_q[$];

  int  mismatch_count = 0;
  int  sent_bytes = 0;
  int  idle_cycles = 0;
  bit  src_idles = 1'b1;
  bit  sink_idles = 1'b1;
  int  sink_stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive every input to a known value from time zero.
  initial begin
    rst = 1'b1;
    chunk_if.valid = 1'b0;
    chunk_if.data_byte = 8'h00;
    chunk_if.last_byte = 1'b0;
    result_if.ready = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return to the version byte; position words survive a restart.
  function automatic void restart_parser();
    cur_phase = PH_VERSION;
    field_cnt = '0;
    field_acc = '0;
    entries_rem = '0;
    frame_err = svcd_pkg::STATUS_OK;
  endfunction

  // Shift one byte into the little-endian accumulator.
  function automatic void take_field_byte(input logic [7:0] b);
    field_acc = field_acc | (32'(b) << (8 * field_cnt[1:0]));
    field_cnt = field_cnt + 4'd1;
  endfunction

  // Advance the parser by one byte and return the result word it must produce.
  function automatic decoded_word_t decode_byte(input logic [7:0] b, input logic last);
    decoded_word_t     w;
    logic              ended;
    logic              draining;
    svcd_pkg::status_t err;
    w.res = '0;
    ended = 1'b0;
    err = svcd_pkg::STATUS_OK;
    draining = (cur_phase == PH_DRAIN);
    case (cur_phase)
      PH_VERSION: begin
        if (b != svcd_pkg::FORMAT_VERSION) begin
          err = svcd_pkg::STATUS_BAD_VERSION;
          ended = 1'b1;
        end else begin
          cur_phase = PH_POSITION;
          field_cnt = '0;
          field_acc = '0;
        end
      end
      PH_POSITION: begin
        take_field_byte(b);
        // Commit a position word on its fourth byte: x, y, then z.
        if (field_cnt[1:0] == 2'd0) begin
          pos_words[field_cnt[3:2] - 2'd1] = field_acc;
          field_acc = '0;
        end
        if (field_cnt >= 4'd12) begin
          cur_phase = PH_COUNT;
          field_cnt = '0;
        end
      end
      PH_COUNT: begin
        take_field_byte(b);
        if (field_cnt >= 4'd4) begin
          entries_rem = field_acc;
          field_acc = '0;
          field_cnt = '0;
          w.res.clear_store = 1'b1;
          if (entries_rem == 32'd0) ended = 1'b1;
          else cur_phase = PH_INDEX;
        end
      end
      PH_INDEX: begin
        take_field_byte(b);
        if (field_cnt >= 4'd4) begin
          field_cnt = '0;
          cur_phase = PH_VALUE;
        end
      end
      PH_VALUE: begin
        if (field_acc >= BLOCKS) begin
          err = svcd_pkg::STATUS_RANGE;
          ended = 1'b1;
        end else begin
          w.res.store_write = 1'b1;
          w.res.store_index = field_acc[11:0];
          w.res.store_value = b;
          entries_rem = entries_rem - 32'd1;
          field_acc = '0;
          if (entries_rem == 32'd0) ended = 1'b1;
          else cur_phase = PH_INDEX;
        end
      end
      default: cur_phase = PH_DRAIN;
    endcase

    // A marked byte that ends nothing else means the buffer was too short.
    if (!draining && !ended && last) begin
      err = svcd_pkg::STATUS_TOO_SHORT;
      ended = 1'b1;
    end
    if (ended) begin
      w.res.frame_done = 1'b1;
      w.res.status = err;
      frame_err = err;
      cur_phase = PH_DRAIN;
    end else if (draining) begin
      w.res.frame_done = last;
      w.res.status = last ? frame_err : svcd_pkg::STATUS_OK;
    end
    if (last) restart_parser();

    w.px = pos_words[0];
    w.py = pos_words[1];
    w.pz = pos_words[2];
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Mostly back to back, sometimes a short gap, rarely a long one.
  function automatic int pick_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 20);
  endfunction

  // Offer one byte word, hold it until taken, then record its prediction.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap(src_idles);
    if (gap > 0) begin
      chunk_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    chunk_if.valid = 1'b1;
    chunk_if.data_byte = b;
    chunk_if.last_byte = last;
    @(posedge clk);
    while (!chunk_if.ready) @(posedge clk);
    sent_bytes++;
    pending_results.insert(pending_results.size(), decode_byte(b, last));
    @(negedge clk);
  endtask

  // Send the assembled buffer with the last mark on its final byte, then clear it.
  task automatic send_frame();
    foreach (frame_q[i]) send_byte(frame_q[i], i == frame_q.size() - 1);
    frame_q.delete();
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic wait_drained();
    chunk_if.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Append one byte to the buffer under construction.
  function automatic void add_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endfunction

  function automatic void put_word(input logic [31:0] w);
    for (int i = 0; i < 4; i++) add_byte(w[8*i +: 8]);
  endfunction

  function automatic void put_header(input logic [31:0] x, input logic [31:0] y,
                                     input logic [31:0] z, input logic [31:0] count);
    add_byte(svcd_pkg::FORMAT_VERSION);
    put_word(x);
    put_word(y);
    put_word(z);
    put_word(count);
  endfunction

  function automatic void put_entry(input logic [31:0] idx, input logic [7:0] val);
    put_word(idx);
    add_byte(val);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, with stretches of steady ready
  // ---------------------------------------------------------------------------
  initial begin
    forever begin
      @(negedge clk);
      if (sink_stall_left > 0) begin
        result_if.ready = 1'b0;
        sink_stall_left--;
      end else begin
        result_if.ready = 1'b1;
        if (sink_idles && $urandom_range(0, 3) == 0) sink_stall_left = pick_gap(1'b1);
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each taken result word against the oldest prediction.
  always @(posedge clk) begin : check_results
    decoded_word_t want;
    if (!rst && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result word with no byte pending", $time);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("store_write", want.res.store_write, result_if.store_write);
        check_field("store_index", want.res.store_index, result_if.store_index);
        check_field("store_value", want.res.store_value, result_if.store_value);
        check_field("clear_store", want.res.clear_store, result_if.clear_store);
        check_field("frame_done", want.res.frame_done, result_if.frame_done);
        check_field("status", want.res.status, result_if.status);
        check_field("pos_x", want.px, result_if.pos_x);
        check_field("pos_y", want.py, result_if.pos_y);
        check_field("pos_z", want.pz, result_if.pos_z);
      end
    end
  end

  // Watchdog: end the run when neither side moves a word for too long.
  always @(posedge clk) begin
    if ((chunk_if.valid && chunk_if.ready) || (result_if.valid && result_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_CYCLES);
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Bad version alone, bad version followed by trailing bytes, and a lone good
  // version byte that ends the buffer.
  task automatic test_version_errors();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(svcd_pkg::FORMAT_VERSION, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(svcd_pkg::FORMAT_VERSION, 1'b1);
  endtask

  // Zero entries completes on the count field; a trailing byte then drains.
  task automatic test_zero_count();
    put_header(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
    add_byte(8'hAA);
    send_frame();
  endtask

  // Two good writes at both ends of the index range and value range.
  task automatic test_store_writes();
    put_header(32'h0000_0000, 32'h0000_0001, 32'($urandom), 32'd2);
    put_entry(32'd0, 8'h00);
    put_entry(BLOCKS - 1, 8'hFF);
    send_frame();
  endtask

  // One good entry, then an index just past the store, then a trailing byte.
  task automatic test_index_range();
    put_header(32'($urandom), 32'($urandom), 32'($urandom), 32'd3);
    put_entry(32'd7, 8'h5A);
    put_entry(BLOCKS, 8'h11);
    add_byte(8'h3C);
    send_frame();
  endtask

  // Buffers cut on the count field, inside an index and on a value byte.
  task automatic test_truncated();
    put_header(32'($urandom), 32'($urandom), 32'($urandom), 32'd5);
    send_frame();
    put_header(32'($urandom), 32'($urandom), 32'($urandom), 32'd4);
    put_entry(32'd100, 8'h42);
    add_byte(8'h05);
    add_byte(8'h01);
    send_frame();
    put_header(32'($urandom), 32'($urandom), 32'($urandom), 32'd9);
    put_entry(32'd12, 8'hC3);
    send_frame();
  endtask

  function automatic logic [31:0] rand_position();
    case ($urandom_range(0, 11))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_index();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return BLOCKS;
    if (r < 6) return 32'($urandom) | 32'h0000_1000;
    if (r < 10) return (r < 8) ? 32'd0 : BLOCKS - 1;
    return $urandom_range(0, BLOCKS - 1);
  endfunction

  // Mostly well-formed chunks with random content; the rest is noise, bad
  // versions, cut buffers and trailing junk.
  task automatic build_random_frame();
    int          kind;
    int          r;
    int unsigned n_entries;
    int unsigned cut;
    logic [7:0]  b;
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 12)) add_byte(8'($urandom));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 5) n_entries = 0;
    else if (r < 90) n_entries = $urandom_range(1, 6);
    else n_entries = $urandom_range(7, 24);
    put_header(rand_position(), rand_position(), rand_position(), n_entries);
    if (kind < 13) begin
      b = 8'($urandom);
      if (b == svcd_pkg::FORMAT_VERSION) b = 8'h00;
      frame_q[0] = b;
    end
    repeat (n_entries) put_entry(rand_index(), 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 15) begin
      cut = $urandom_range(1, frame_q.size() - 1);
      frame_q = frame_q[0:cut-1];
    end else if (r < 35) begin
      repeat ($urandom_range(1, 5)) add_byte(8'($urandom));
    end
  endtask

  task automatic test_random_chunks();
    int start;
    int frames;
    start = sent_bytes;
    frames = 0;
    while (sent_bytes - start < RANDOM_BYTES) begin
      // Switch idling on and off now and then so that calm stretches occur.
      if (frames % 8 == 0) begin
        src_idles = ($urandom_range(0, 3) != 0);
        sink_idles = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 14) == 0) wait_drained();
      build_random_frame();
      send_frame();
      frames++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    restart_parser();
    pos_words[0] = '0;
    pos_words[1] = '0;
    pos_words[2] = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_version_errors();
    wait_drained();
    test_zero_count();
    test_store_writes();
    wait_drained();
    test_index_range();
    test_truncated();
    test_random_chunks();

    // Stop offering words, let every prediction come back, then settle.
    src_idles = 1'b0;
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result words never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
